[rtl/hex_lattice_gas_streaming_defines.svh]
// ----------------------------------------------------------------------------
// Hex lattice gas streaming: assertion macros
// Shorthand for the concurrent checks of the top level. All checks sample on
// clk_i and are off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HEX_LATTICE_GAS_STREAMING_DEFINES_SVH
`define HEX_LATTICE_GAS_STREAMING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HLG_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hlg_pkg.sv]
// ----------------------------------------------------------------------------
// Hex lattice gas streaming: package
// Word types, register codes, sizes and the hexagonal neighbor tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hlg_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  localparam int unsigned MIN_DIM       = 2;
  localparam int unsigned RESET_WIDTH   = 256;
  localparam int unsigned RESET_HEIGHT  = 256;
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned ROW_W         = 11;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH     = 4;
  localparam int unsigned NUM_DIRS      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic       flush;
    logic       obstacle;
    logic [6:0] cell_state;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_state;
    logic       out_obstacle;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic       obstacle;
    logic [6:0] state;
  } cell_t;

  // Position class of the cell that leaves the window with a given word.
  typedef struct packed {
    logic emit;
    logic frame_end;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic odd;
  } cls_t;

  // Opposite direction and window offsets plus one, indexed by direction.
  localparam logic [2:0] OPP_DIR [NUM_DIRS] = '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2};
  localparam logic [1:0] DY1     [NUM_DIRS] = '{2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] DXE1    [NUM_DIRS] = '{2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] DXO1    [NUM_DIRS] = '{2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2};

endpackage

`default_nettype wire

[rtl/hlg_queue.sv]
// ----------------------------------------------------------------------------
// Hex lattice gas streaming: word queue
// Small register queue with valid/ready on both sides and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module hlg_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire logic [DW-1:0] push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output logic [DW-1:0]      pop_data_o,
  output logic [CW-1:0]      count_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign count_o      = count_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/hlg_front.sv]
// ----------------------------------------------------------------------------
// Hex lattice gas streaming: front end
// Holds the grid size registers and the raster position, accepts cells and
// tags each word with the class of the cell that it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module hlg_front import hlg_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned XW       = $clog2(MAX_WIDTH),
  localparam int unsigned XCW      = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_data_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output cell_t                     push_cell_o,
  output logic [XW-1:0]             push_col_o,
  output cls_t                      push_cls_o
);

  localparam int unsigned W_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [XCW-1:0]   w_q, w_d, w_sat;
  logic [ROW_W-1:0] h_q, h_d, h_sat;
  logic [XW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [XW-1:0]    xi;
  logic [XCW-1:0]   xi_inc;
  logic             wrap, xi_zero, lead, ovf, accept, restart;
  logic [ROW_W-1:0] h_p1, h_p2;
  cls_t             cls;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = push_ready_i;
  assign accept      = in_valid_i && push_ready_i;

  always_comb begin
    if (cfg_data_i < CFG_W'(MIN_DIM)) begin
      w_sat = XCW'(MIN_DIM);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      w_sat = XCW'(MAX_WIDTH);
    end else begin
      w_sat = XCW'(cfg_data_i);
    end
    if (cfg_data_i < CFG_W'(MIN_DIM)) begin
      h_sat = ROW_W'(MIN_DIM);
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      h_sat = ROW_W'(MAX_HEIGHT);
    end else begin
      h_sat = ROW_W'(cfg_data_i);
    end
  end

  always_comb begin
    xi      = (XCW'(col_q) >= w_q) ? '0 : col_q;
    xi_inc  = XCW'(xi) + XCW'(1);
    wrap    = (xi_inc >= w_q);
    xi_zero = (xi == '0);
    h_p1    = h_q + ROW_W'(1);
    h_p2    = h_q + ROW_W'(2);
    lead    = (row_q == '0) || ((row_q == ROW_W'(1)) && xi_zero);
    ovf     = xi_zero ? (row_q >= h_p2) : (row_q >= h_p1);

    cls.emit      = !lead && !ovf;
    cls.frame_end = xi_zero && (row_q == h_p1);
    cls.top       = xi_zero ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
    cls.bottom    = xi_zero ? (row_q == h_p1) : (row_q == h_q);
    cls.left      = (xi == XW'(1));
    cls.right     = xi_zero;
    cls.odd       = xi_zero ? row_q[0] : ~row_q[0];
    restart       = !lead && (ovf || cls.frame_end);
  end

  always_comb begin
    w_d   = w_q;
    h_d   = h_q;
    col_d = col_q;
    row_d = row_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GRID_WIDTH: begin
          w_d   = w_sat;
          col_d = '0;
          row_d = '0;
        end
        REG_GRID_HEIGHT: begin
          h_d   = h_sat;
          col_d = '0;
          row_d = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      col_d = wrap ? '0 : xi_inc[XW-1:0];
      if (wrap && (row_q < h_p2)) begin
        row_d = row_q + ROW_W'(1);
      end
      if (restart) begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= XCW'(W_RST);
      h_q   <= ROW_W'(RESET_HEIGHT);
      col_q <= '0;
      row_q <= '0;
    end else begin
      w_q   <= w_d;
      h_q   <= h_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_valid_o = in_valid_i;
  assign push_col_o   = xi;
  assign push_cls_o   = cls;
  assign push_cell_o  = in_data_i.flush ? '0 : cell_t'({in_data_i.obstacle, in_data_i.cell_state});

endmodule

`default_nettype wire

[rtl/hlg_back.sv]
// ----------------------------------------------------------------------------
// Hex lattice gas streaming: back end
// Two line buffers and a neighbor window; computes the propagated state of
// the window center and hands finished words to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hlg_back import hlg_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned ODEPTH    = OUT_DEPTH,
  localparam int unsigned XW       = $clog2(MAX_WIDTH),
  localparam int unsigned OCW      = $clog2(ODEPTH + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire cell_t          pop_cell_i,
  input  wire logic [XW-1:0]  pop_col_i,
  input  wire cls_t           pop_cls_i,
  input  wire logic [OCW-1:0] out_count_i,
  output logic                push_valid_o,
  output out_item_t           push_data_o
);

  cell_t          upper_mem_q  [MAX_WIDTH];
  cell_t          middle_mem_q [MAX_WIDTH];
  cell_t          up_rd_q, mid_rd_q;
  logic           a_valid_q;
  cell_t          a_cell_q;
  logic [XW-1:0]  a_col_q;
  cls_t           a_cls_q;
  cell_t          win_q [2][3];
  cell_t          p     [3][3];
  logic           pop;
  logic [6:0]     res;

  assign pop_ready_o = (int'(out_count_i) + int'(a_valid_q)) < ODEPTH;
  assign pop         = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (a_valid_q && (a_col_q == pop_col_i)) begin
        up_rd_q <= mid_rd_q;
      end else begin
        up_rd_q <= upper_mem_q[pop_col_i];
      end
      mid_rd_q                <= middle_mem_q[pop_col_i];
      middle_mem_q[pop_col_i] <= pop_cell_i;
      a_cell_q                <= pop_cell_i;
      a_col_q                 <= pop_col_i;
      a_cls_q                 <= pop_cls_i;
    end
    if (a_valid_q) begin
      upper_mem_q[a_col_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else begin
      a_valid_q <= pop;
      if (a_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[0][r] <= win_q[1][r];
        end
        win_q[1][0] <= up_rd_q;
        win_q[1][1] <= mid_rd_q;
        win_q[1][2] <= a_cell_q;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p[r][0] = win_q[0][r];
      p[r][1] = win_q[1][r];
    end
    p[0][2] = up_rd_q;
    p[1][2] = mid_rd_q;
    p[2][2] = a_cell_q;
  end

  // A particle enters from the opposite neighbor, bounces off an obstacle or
  // the top and bottom edges, and is lost past the left and right edges.
  always_comb begin
    logic [2:0] s;
    logic [1:0] ry, rx;
    logic       row_in, col_in;
    cell_t      nb;
    res = {p[1][1].state[6], 6'b0};
    for (int e = 0; e < NUM_DIRS; e++) begin
      s      = OPP_DIR[e];
      ry     = DY1[s];
      rx     = a_cls_q.odd ? DXO1[s] : DXE1[s];
      row_in = !(((ry == 2'd0) && a_cls_q.top) || ((ry == 2'd2) && a_cls_q.bottom));
      col_in = !(((rx == 2'd0) && a_cls_q.left) || ((rx == 2'd2) && a_cls_q.right));
      nb     = p[ry][rx];
      if (row_in && col_in && !nb.obstacle && nb.state[e]) begin
        res[e] = 1'b1;
      end
      if (p[1][1].state[s] && (!row_in || (col_in && nb.obstacle))) begin
        res[e] = 1'b1;
      end
    end
    if (p[1][1].obstacle) begin
      res = '0;
    end
  end

  assign push_valid_o             = a_valid_q && a_cls_q.emit;
  assign push_data_o.out_state    = res;
  assign push_data_o.out_obstacle = p[1][1].obstacle;
  assign push_data_o.frame_end    = a_cls_q.frame_end;

endmodule

`default_nettype wire

[rtl/hex_lattice_gas_streaming.sv]
// ----------------------------------------------------------------------------
// Hex lattice gas streaming
// Propagation step of a hexagonal lattice gas over a raster-ordered stream.
// ----------------------------------------------------------------------------
// The block takes one cell word per clock and sustains one result word per
// clock unless out_ready_i holds back the result side; each line-buffer
// port is used once per cell, which sets that rate. The next state of a cell
// leaves W+1 input words after the cell itself and then passes the input
// queue, the back end register stage and the output queue, so a frame of W*H
// cells needs W+1 trailing flush words. The line buffers need no clearing
// after reset. A front end with the position counters feeds a four-word
// queue, the back end holds the line buffers and the window, and a four-word
// output queue decouples the result side.
`default_nettype none

`include "hex_lattice_gas_streaming_defines.svh"

module hex_lattice_gas_streaming import hlg_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_data_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned QDW = $bits(cell_t) + XW + $bits(cls_t);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  logic            q_push, q_push_ready, q_pop, q_pop_valid;
  cell_t           f_cell, b_cell;
  logic [XW-1:0]   f_col, b_col;
  cls_t            f_cls, b_cls;
  logic [QDW-1:0]  q_in, q_out;
  logic [QCW-1:0]  q_count;
  logic            o_push, o_push_ready;
  out_item_t       o_data;
  logic [OCW-1:0]  out_count;
  logic [$bits(out_item_t)-1:0] o_head;

  hlg_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(q_push),
    .push_ready_i(q_push_ready),
    .push_cell_o (f_cell),
    .push_col_o  (f_col),
    .push_cls_o  (f_cls)
  );

  assign q_in = {f_cell, f_col, f_cls};

  hlg_queue #(
    .DW   (QDW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push),
    .push_ready_o(q_push_ready),
    .push_data_i (q_in),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop),
    .pop_data_o  (q_out),
    .count_o     (q_count)
  );

  assign b_cell = cell_t'(q_out[QDW-1 -: $bits(cell_t)]);
  assign b_col  = q_out[$bits(cls_t) +: XW];
  assign b_cls  = cls_t'(q_out[$bits(cls_t)-1:0]);

  hlg_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .ODEPTH   (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop),
    .pop_cell_i  (b_cell),
    .pop_col_i   (b_col),
    .pop_cls_i   (b_cls),
    .out_count_i (out_count),
    .push_valid_o(o_push),
    .push_data_o (o_data)
  );

  hlg_queue #(
    .DW   ($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(o_push),
    .push_ready_o(o_push_ready),
    .push_data_i (o_data),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (o_head),
    .count_o     (out_count)
  );

  assign out_data_o = out_item_t'(o_head);

  `HLG_ASSERT(a_out_no_overflow, o_push, o_push_ready, "result word pushed into a full queue")
  `HLG_ASSERT(a_back_credit, out_count == OCW'(OUT_DEPTH), !q_pop, "back end took a word without room")
  `HLG_ASSERT_NEXT(a_queue_fill, (q_count == QCW'(QUEUE_DEPTH - 1)) && q_push && q_push_ready && !q_pop, !in_ready_o, "input ready while queue full")

endmodule

`default_nettype wire
